// ===== design/rab_pkg.sv =====
// shared widths, register indexes and limits for the row activity bounds block
package rab_pkg;

  localparam int ROW_W     = 16;
  localparam int VAL_W     = 32;
  localparam int COL_W     = 12;
  localparam int CNT_W     = 13;
  localparam int SUM_W     = 64;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_COLUMNS = 4096;

  localparam logic [CNT_W-1:0] COUNT_CAP           = '1;
  localparam logic [CFG_W-1:0] COEFF_EPSILON_RESET = '0;
  localparam logic [CFG_W-1:0] INF_THRESHOLD_RESET = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_EPSILON = 1'b0,
    REG_INF_THRESHOLD = 1'b1
  } cfg_reg_t;

endpackage

// ===== design/rab_entry_if.sv =====
// stream channel carrying one row entry with its column bounds
interface rab_entry_if;
  logic                                valid;
  logic                                ready;
  logic        [rab_pkg::ROW_W-1:0]    row_id;
  logic signed [rab_pkg::VAL_W-1:0]    coefficient;
  logic signed [rab_pkg::VAL_W-1:0]    lower_bound;
  logic signed [rab_pkg::VAL_W-1:0]    upper_bound;
  logic        [rab_pkg::COL_W-1:0]    column;
  logic                                last_in_row;

  modport source (
    output valid, row_id, coefficient, lower_bound, upper_bound, column, last_in_row,
    input  ready
  );
  modport sink (
    input  valid, row_id, coefficient, lower_bound, upper_bound, column, last_in_row,
    output ready
  );
endinterface

// ===== design/rab_result_if.sv =====
// stream channel carrying the activity bounds of one finished row
interface rab_result_if;
  logic                                valid;
  logic                                ready;
  logic        [rab_pkg::ROW_W-1:0]    row_tag;
  logic signed [rab_pkg::SUM_W-1:0]    min_sum;
  logic        [rab_pkg::CNT_W-1:0]    min_inf_count;
  logic        [rab_pkg::COL_W-1:0]    min_inf_col;
  logic signed [rab_pkg::SUM_W-1:0]    max_sum;
  logic        [rab_pkg::CNT_W-1:0]    max_inf_count;
  logic        [rab_pkg::COL_W-1:0]    max_inf_col;

  modport source (
    output valid, row_tag, min_sum, min_inf_count, min_inf_col,
           max_sum, max_inf_count, max_inf_col,
    input  ready
  );
  modport sink (
    input  valid, row_tag, min_sum, min_inf_count, min_inf_col,
           max_sum, max_inf_count, max_inf_col,
    output ready
  );
endinterface

// ===== design/row_activity_bounds.sv =====
// row activity bounds: min and max activity of a constraint row, one entry per transfer
//
// Takes one row entry per clock and keeps that rate for as long as the result side
// drains. An entry passes an input register, then a stage with the two 32x32 signed
// multipliers that form the min and max terms, then the saturating 64-bit accumulate
// into the running sums, which is the loop that sets the rate of one entry per cycle.
// A row's summary is valid on the result channel after its last entry passes the input,
// product and output registers. Entries of the next row are taken while a summary waits
// on the output, until the last entry of that next row reaches the product stage.
// Configuration writes are meant to happen while no row is in flight.
module row_activity_bounds (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rab_pkg::CFG_W-1:0]           cfg_data,
  rab_entry_if.sink                           entry,
  rab_result_if.source                        result
);

  localparam int MAG_W = rab_pkg::VAL_W + 1;

  function automatic logic signed [rab_pkg::SUM_W-1:0] sat_add(
    input logic signed [rab_pkg::SUM_W-1:0] acc,
    input logic signed [rab_pkg::SUM_W-1:0] term
  );
    logic signed [rab_pkg::SUM_W-1:0] sum;
    logic                             ovf;
    sum = acc + term;
    ovf = (acc[rab_pkg::SUM_W-1] == term[rab_pkg::SUM_W-1]) &&
          (sum[rab_pkg::SUM_W-1] != acc[rab_pkg::SUM_W-1]);
    if (ovf) begin
      sat_add = acc[rab_pkg::SUM_W-1] ? {1'b1, {(rab_pkg::SUM_W-1){1'b0}}}
                                      : {1'b0, {(rab_pkg::SUM_W-1){1'b1}}};
    end else begin
      sat_add = sum;
    end
  endfunction

  // configuration
  logic [rab_pkg::CFG_W-1:0] coeff_epsilon;
  logic [rab_pkg::CFG_W-1:0] inf_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_epsilon <= rab_pkg::COEFF_EPSILON_RESET;
      inf_threshold <= rab_pkg::INF_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rab_pkg::REG_COEFF_EPSILON: coeff_epsilon <= cfg_data;
        rab_pkg::REG_INF_THRESHOLD: inf_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                              a_valid;
  logic [rab_pkg::ROW_W-1:0]         a_row;
  logic signed [rab_pkg::VAL_W-1:0]  a_coef;
  logic signed [rab_pkg::VAL_W-1:0]  a_lo;
  logic signed [rab_pkg::VAL_W-1:0]  a_up;
  logic [rab_pkg::COL_W-1:0]         a_col;
  logic                              a_last;

  // product register
  logic                              b_valid;
  logic [rab_pkg::ROW_W-1:0]         b_row;
  logic [rab_pkg::COL_W-1:0]         b_col;
  logic                              b_last;
  logic                              b_use;
  logic                              b_min_inf;
  logic                              b_max_inf;
  logic signed [rab_pkg::SUM_W-1:0]  b_min_prod;
  logic signed [rab_pkg::SUM_W-1:0]  b_max_prod;

  // accumulators
  logic signed [rab_pkg::SUM_W-1:0]  min_acc;
  logic signed [rab_pkg::SUM_W-1:0]  max_acc;
  logic [rab_pkg::CNT_W-1:0]         min_count;
  logic [rab_pkg::CNT_W-1:0]         max_count;
  logic [rab_pkg::COL_W-1:0]         min_col;
  logic [rab_pkg::COL_W-1:0]         max_col;

  logic signed [rab_pkg::SUM_W-1:0]  min_acc_next;
  logic signed [rab_pkg::SUM_W-1:0]  max_acc_next;
  logic [rab_pkg::CNT_W-1:0]         min_count_next;
  logic [rab_pkg::CNT_W-1:0]         max_count_next;
  logic [rab_pkg::COL_W-1:0]         min_col_next;
  logic [rab_pkg::COL_W-1:0]         max_col_next;

  // output register
  logic                              out_valid;
  logic [rab_pkg::ROW_W-1:0]         out_row;
  logic signed [rab_pkg::SUM_W-1:0]  out_min_sum;
  logic [rab_pkg::CNT_W-1:0]         out_min_count;
  logic [rab_pkg::COL_W-1:0]         out_min_col;
  logic signed [rab_pkg::SUM_W-1:0]  out_max_sum;
  logic [rab_pkg::CNT_W-1:0]         out_max_count;
  logic [rab_pkg::COL_W-1:0]         out_max_col;

  logic out_free;
  logic consume_b;
  logic advance_a;
  logic take_in;

  assign out_free  = !out_valid || result.ready;
  // only the last entry of a row needs room in the output register
  assign consume_b = b_valid && (!b_last || out_free);
  assign advance_a = a_valid && (!b_valid || consume_b);
  assign entry.ready = !a_valid || advance_a;
  assign take_in   = entry.valid && entry.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take_in) begin
      a_valid <= 1'b1;
    end else if (advance_a) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      a_row  <= entry.row_id;
      a_coef <= entry.coefficient;
      a_lo   <= entry.lower_bound;
      a_up   <= entry.upper_bound;
      a_col  <= entry.column;
      a_last <= entry.last_in_row;
    end
  end

  // term selection and products
  logic [MAG_W-1:0]                 mag;
  logic signed [MAG_W-1:0]          lo_x;
  logic signed [MAG_W-1:0]          up_x;
  logic signed [MAG_W-1:0]          thr_x;
  logic signed [MAG_W-1:0]          neg_thr;
  logic                             lo_inf;
  logic                             up_inf;
  logic                             pos;
  logic                             col_ok;
  logic                             use_term;
  logic signed [rab_pkg::VAL_W-1:0] min_bound;
  logic signed [rab_pkg::VAL_W-1:0] max_bound;
  logic signed [rab_pkg::SUM_W-1:0] min_prod;
  logic signed [rab_pkg::SUM_W-1:0] max_prod;

  always_comb begin
    mag      = a_coef[rab_pkg::VAL_W-1] ? (MAG_W'(0) - MAG_W'(a_coef)) : MAG_W'(a_coef);
    lo_x     = MAG_W'(a_lo);
    up_x     = MAG_W'(a_up);
    thr_x    = $signed({2'b00, inf_threshold});
    neg_thr  = -thr_x;
    lo_inf   = lo_x <= neg_thr;
    up_inf   = up_x >= thr_x;
    pos      = !a_coef[rab_pkg::VAL_W-1] && (a_coef != '0);
    col_ok   = 32'(a_col) < rab_pkg::MAX_COLUMNS;
    use_term = col_ok && (mag > {2'b00, coeff_epsilon});
    // a negative coefficient swaps which bound feeds each side
    min_bound = pos ? a_lo : a_up;
    max_bound = pos ? a_up : a_lo;
    min_prod  = a_coef * min_bound;
    max_prod  = a_coef * max_bound;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance_a) begin
      b_valid <= 1'b1;
    end else if (consume_b) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_a) begin
      b_row      <= a_row;
      b_col      <= a_col;
      b_last     <= a_last;
      b_use      <= use_term;
      b_min_inf  <= pos ? lo_inf : up_inf;
      b_max_inf  <= pos ? up_inf : lo_inf;
      b_min_prod <= min_prod;
      b_max_prod <= max_prod;
    end
  end

  // accumulate
  always_comb begin
    min_acc_next   = min_acc;
    max_acc_next   = max_acc;
    min_count_next = min_count;
    max_count_next = max_count;
    min_col_next   = min_col;
    max_col_next   = max_col;
    if (b_use) begin
      if (b_min_inf) begin
        if (min_count != rab_pkg::COUNT_CAP) begin
          min_count_next = min_count + 1'b1;
        end
        min_col_next = b_col;
      end else begin
        min_acc_next = sat_add(min_acc, b_min_prod);
      end
      if (b_max_inf) begin
        if (max_count != rab_pkg::COUNT_CAP) begin
          max_count_next = max_count + 1'b1;
        end
        max_col_next = b_col;
      end else begin
        max_acc_next = sat_add(max_acc, b_max_prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_acc   <= '0;
      max_acc   <= '0;
      min_count <= '0;
      max_count <= '0;
      min_col   <= '0;
      max_col   <= '0;
    end else if (consume_b) begin
      if (b_last) begin
        min_acc   <= '0;
        max_acc   <= '0;
        min_count <= '0;
        max_count <= '0;
        min_col   <= '0;
        max_col   <= '0;
      end else begin
        min_acc   <= min_acc_next;
        max_acc   <= max_acc_next;
        min_count <= min_count_next;
        max_count <= max_count_next;
        min_col   <= min_col_next;
        max_col   <= max_col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume_b && b_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume_b && b_last) begin
      out_row       <= b_row;
      out_min_sum   <= min_acc_next;
      out_min_count <= min_count_next;
      out_min_col   <= min_col_next;
      out_max_sum   <= max_acc_next;
      out_max_count <= max_count_next;
      out_max_col   <= max_col_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.row_tag       = out_row;
  assign result.min_sum       = out_min_sum;
  assign result.min_inf_count = out_min_count;
  assign result.min_inf_col   = out_min_col;
  assign result.max_sum       = out_max_sum;
  assign result.max_inf_count = out_max_count;
  assign result.max_inf_col   = out_max_col;

endmodule

// ===== sim/rab_activity_checker.sv =====
// scoreboard for row_activity_bounds: predicts each row summary from the entry stream and compares
module rab_activity_checker
  import rab_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rab_entry_if                 entry,
  rab_result_if                result,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 50;

  typedef struct {
    logic        [ROW_W-1:0] row_tag;
    logic signed [SUM_W-1:0] min_sum;
    logic        [CNT_W-1:0] min_inf_count;
    logic        [COL_W-1:0] min_inf_col;
    logic signed [SUM_W-1:0] max_sum;
    logic        [CNT_W-1:0] max_inf_count;
    logic        [COL_W-1:0] max_inf_col;
  } row_bounds_t;

  row_bounds_t expected_bounds[$];

  logic        [CFG_W-1:0] coeff_eps;
  logic        [CFG_W-1:0] inf_thr;
  logic signed [SUM_W-1:0] min_acc, max_acc;
  logic        [CNT_W-1:0] min_cnt, max_cnt;
  logic        [COL_W-1:0] min_col, max_col;

  function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [SUM_W-1:0] acc,
                                                      logic signed [SUM_W-1:0] term);
    logic signed [SUM_W-1:0] r;
    r = acc + term;
    // same-sign operands with a flipped result sign means overflow
    if (acc[SUM_W-1] == term[SUM_W-1] && r[SUM_W-1] != acc[SUM_W-1])
      r = acc[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return r;
  endfunction

  function automatic void fold_term(inout logic signed [SUM_W-1:0] acc,
                                    inout logic [CNT_W-1:0] cnt,
                                    inout logic [COL_W-1:0] col,
                                    input bit infinite, input longint term,
                                    input logic [COL_W-1:0] c);
    if (infinite) begin
      if (cnt != COUNT_CAP) cnt++;
      col = c;
    end else begin
      acc = sat_sum(acc, term);
    end
  endfunction

  function automatic void clear_row();
    min_acc = '0;
    max_acc = '0;
    min_cnt = '0;
    max_cnt = '0;
    min_col = '0;
    max_col = '0;
  endfunction

  function automatic void fold_entry();
    longint      a, lo, up, mag, thr_l, eps_l;
    bit          lo_inf, up_inf;
    row_bounds_t done;
    a     = longint'(entry.coefficient);
    lo    = longint'(entry.lower_bound);
    up    = longint'(entry.upper_bound);
    thr_l = longint'(inf_thr);
    eps_l = longint'(coeff_eps);
    mag   = (a < 0) ? -a : a;
    if (entry.column < MAX_COLUMNS && mag > eps_l) begin
      lo_inf = lo <= -thr_l;
      up_inf = up >= thr_l;
      if (a > 0) begin
        fold_term(min_acc, min_cnt, min_col, lo_inf, a * lo, entry.column);
        fold_term(max_acc, max_cnt, max_col, up_inf, a * up, entry.column);
      end else begin
        fold_term(min_acc, min_cnt, min_col, up_inf, a * up, entry.column);
        fold_term(max_acc, max_cnt, max_col, lo_inf, a * lo, entry.column);
      end
    end
    if (entry.last_in_row) begin
      done.row_tag       = entry.row_id;
      done.min_sum       = min_acc;
      done.min_inf_count = min_cnt;
      done.min_inf_col   = min_col;
      done.max_sum       = max_acc;
      done.max_inf_count = max_cnt;
      done.max_inf_col   = max_col;
      expected_bounds.push_back(done);
      clear_row();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (errors < PRINT_CAP)
      $display("%t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_row();
    row_bounds_t want;
    if (expected_bounds.size() == 0) begin
      report_mismatch("row with nothing pending, row_tag", 64'(result.row_tag), '0);
    end else begin
      want = expected_bounds.pop_front();
      if (result.row_tag !== want.row_tag)
        report_mismatch("row_tag", 64'(result.row_tag), 64'(want.row_tag));
      if (result.min_sum !== want.min_sum)
        report_mismatch("min_sum", result.min_sum, want.min_sum);
      if (result.min_inf_count !== want.min_inf_count)
        report_mismatch("min_inf_count", 64'(result.min_inf_count),
                        64'(want.min_inf_count));
      if (result.min_inf_col !== want.min_inf_col)
        report_mismatch("min_inf_col", 64'(result.min_inf_col), 64'(want.min_inf_col));
      if (result.max_sum !== want.max_sum)
        report_mismatch("max_sum", result.max_sum, want.max_sum);
      if (result.max_inf_count !== want.max_inf_count)
        report_mismatch("max_inf_count", 64'(result.max_inf_count),
                        64'(want.max_inf_count));
      if (result.max_inf_col !== want.max_inf_col)
        report_mismatch("max_inf_col", 64'(result.max_inf_col), 64'(want.max_inf_col));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      coeff_eps = COEFF_EPSILON_RESET;
      inf_thr   = INF_THRESHOLD_RESET;
      clear_row();
      expected_bounds.delete();
      errors = 0;
    end else begin
      if (result.valid && result.ready) check_row();
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_COEFF_EPSILON: coeff_eps = cfg_data;
          REG_INF_THRESHOLD: inf_thr   = cfg_data;
          default: ;
        endcase
      end
      if (entry.valid && entry.ready) fold_entry();
    end
    pending = expected_bounds.size();
  end

endmodule

// ===== sim/tb_row_activity_bounds.sv =====
// top of the row_activity_bounds testbench: clock, reset, entry and config stimulus, verdict
module tb_row_activity_bounds;
  timeunit 1ns;
  timeprecision 1ps;

  import rab_pkg::*;

  localparam int     BLOCK_ITEMS  = 290;
  localparam int     BLOCKS       = 6;
  localparam int     INF_ROW_LEN  = 160;
  localparam int     HOLD_CYCLES  = 120;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     QUIET_LIMIT  = 2000;
  localparam longint VAL_MAX      = 64'sh7FFF_FFFF;
  localparam longint VAL_MIN      = -64'sh8000_0000;

  typedef struct {
    logic        [ROW_W-1:0] row_id;
    logic signed [VAL_W-1:0] coefficient;
    logic signed [VAL_W-1:0] lower_bound;
    logic signed [VAL_W-1:0] upper_bound;
    logic        [COL_W-1:0] column;
    logic                    last_in_row;
  } row_entry_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   rows_pending;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_requests = 0;
  int                   holds_served  = 0;
  int                   hold_left     = 0;
  int                   quiet_cycles  = 0;
  logic [CFG_W-1:0]     cur_eps;
  logic [CFG_W-1:0]     cur_thr;

  rab_entry_if  entry_ch ();
  rab_result_if result_ch ();

  row_activity_bounds u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .entry     (entry_ch),
    .result    (result_ch)
  );

  rab_activity_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .entry     (entry_ch),
    .result    (result_ch),
    .errors    (mismatches),
    .pending   (rows_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (entry_ch.valid && entry_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // near the edge picks values around edge_mag, the current epsilon or threshold
  function automatic logic signed [VAL_W-1:0] pick_value(longint edge_mag);
    longint v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = longint'($urandom_range(32'hA_0000)) - 64'sh5_0000;
      4, 5:       v = longint'(int'($urandom));
      6: begin
        case ($urandom_range(4))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return '0;
          3:       return 32'sd1;
          default: return '1;
        endcase
      end
      default: begin
        v = edge_mag + longint'($urandom_range(2)) - 1;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    if (v > VAL_MAX) v = VAL_MAX;
    if (v < VAL_MIN) v = VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  task automatic send_entry(row_entry_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      entry_ch.valid <= 1'b0;
      @(negedge clk);
    end
    entry_ch.valid       <= 1'b1;
    entry_ch.row_id      <= e.row_id;
    entry_ch.coefficient <= e.coefficient;
    entry_ch.lower_bound <= e.lower_bound;
    entry_ch.upper_bound <= e.upper_bound;
    entry_ch.column      <= e.column;
    entry_ch.last_in_row <= e.last_in_row;
    @(posedge clk);
    while (!entry_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [ROW_W-1:0] tag,
                             input logic [VAL_W-1:0] coef, lo, up,
                             input logic [COL_W-1:0] col, input logic last);
    row_entry_t e;
    e = '{tag, coef, lo, up, col, last};
    send_entry(e);
  endtask

  task automatic send_random_row(output int len);
    logic [ROW_W-1:0] tag;
    row_entry_t       e;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
    tag = ROW_W'($urandom);
    for (int i = 0; i < len; i++) begin
      e.row_id      = ($urandom_range(15) == 0) ? ROW_W'($urandom) : tag;
      e.coefficient = pick_value(cur_eps);
      e.lower_bound = pick_value(cur_thr);
      e.upper_bound = pick_value(cur_thr);
      e.column      = COL_W'($urandom);
      e.last_in_row = (i == len - 1);
      send_entry(e);
    end
  endtask

  task automatic configure(input logic [CFG_W-1:0] eps, input logic [CFG_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COEFF_EPSILON;
    cfg_data  <= eps;
    @(negedge clk);
    cfg_index <= REG_INF_THRESHOLD;
    cfg_data  <= thr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_eps = eps;
    cur_thr = thr;
  endtask

  // wait until every finished row has come out, then let the pipeline empty
  task automatic settle();
    entry_ch.valid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    row_entry_t e;
    int         len;
    int         block_items;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    entry_ch.valid       = 1'b0;
    entry_ch.row_id      = '0;
    entry_ch.coefficient = '0;
    entry_ch.lower_bound = '0;
    entry_ch.upper_bound = '0;
    entry_ch.column      = '0;
    entry_ch.last_in_row = 1'b0;
    cur_eps              = COEFF_EPSILON_RESET;
    cur_thr              = INF_THRESHOLD_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty row: the only coefficient is zero and is skipped
    send_fields(16'hFFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 12'hABC, 1'b1);
    // both signs, full-scale bounds counted infinite at the reset threshold
    send_fields(16'h0000, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 12'hFFF, 1'b0);
    send_fields(16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 12'h000, 1'b1);
    // sums saturate both ways
    send_fields(16'h5A5A, 32'h7FFF_FFFF, 32'h8000_0002, 32'h7FFF_FFFE, 12'h555, 1'b0);
    send_fields(16'h5A5A, 32'h7FFF_FFFF, 32'h8000_0002, 32'h7FFF_FFFE, 12'hAAA, 1'b0);
    send_fields(16'h5A5A, 32'h7FFF_FFFF, 32'h8000_0002, 32'h7FFF_FFFE, 12'h123, 1'b1);
    settle();

    // largest epsilon, zero threshold
    configure('1, '0);
    send_fields(16'hA5A5, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 12'h001, 1'b0);
    send_fields(16'hA5A5, 32'h8000_0000, 32'h0000_0005, 32'hFFFF_FFFB, 12'h002, 1'b0);
    send_fields(16'hA5A5, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 12'h800, 1'b1);
    settle();

    // coefficients at the epsilon edge, bounds at the threshold edge
    configure(CFG_W'(1), CFG_W'(32'h0001_0000));
    send_fields(16'h1234, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 12'h010, 1'b0);
    send_fields(16'h1234, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 12'h020, 1'b0);
    send_fields(16'h1234, 32'h0000_0002, 32'hFFFF_0000, 32'h0000_FFFF, 12'h030, 1'b0);
    send_fields(16'h1234, 32'hFFFF_FFFE, 32'hFFFF_0001, 32'h0001_0000, 12'h040, 1'b0);
    send_fields(16'h1234, 32'h0001_0000, 32'hFFFF_0001, 32'h0001_0001, 12'h050, 1'b1);
    settle();

    // one long row where every term is infinite on both sides
    configure('0, '0);
    for (int i = 0; i < INF_ROW_LEN; i++) begin
      e.row_id      = 16'hC0DE;
      e.coefficient = {1'($urandom), 30'($urandom), 1'b1};
      e.lower_bound = {1'b1, 31'($urandom)};
      e.upper_bound = {1'b0, 31'($urandom)};
      e.column      = COL_W'($urandom);
      e.last_in_row = (i == INF_ROW_LEN - 1);
      send_entry(e);
    end

    for (int blk = 0; blk < BLOCKS; blk++) begin
      settle();
      case (blk)
        0:       configure(COEFF_EPSILON_RESET, INF_THRESHOLD_RESET);
        1:       configure(CFG_W'($urandom_range(32'h2_0000)),
                           CFG_W'($urandom_range(32'h7FFF_FFFF, 32'h1_0000)));
        2:       configure(CFG_W'($urandom), '0);
        3:       configure(CFG_W'($urandom_range(32'h2_0000)),
                           CFG_W'($urandom_range(32'h4_0000)));
        4:       configure('0, '1);
        default: configure(CFG_W'($urandom_range(32'h1000)), CFG_W'($urandom));
      endcase
      if (blk < 2) begin
        send_idle_pct = 19;
        recv_idle_pct = 86;
      end else if (blk < 4) begin
        send_idle_pct = 86;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long result-side hold while entries keep coming
      if (blk == 4) hold_requests++;
      block_items = 0;
      while (block_items < BLOCK_ITEMS) begin
        send_random_row(len);
        block_items += len;
      end
    end

    settle();
    if (mismatches == 0 && rows_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
